// ===== design/co2fca_pkg.sv =====
// shared types, constants and functions of the co2 frame check and average block
`timescale 1ns / 1ps
`default_nettype none

package co2fca_pkg;

  // largest number of samples per result
  localparam int MAX_SAMPLES = 16;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int CNT_W   = 5;
  localparam int SUM_W   = WORD_W + $clog2(MAX_SAMPLES);
  localparam int POS_W   = 4;
  localparam int NWORDS  = 3;
  localparam int WIDX_W  = 2;
  localparam int DCNT_W  = $clog2(SUM_W);
  localparam int PROD_W  = 31;
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [BYTE_W-1:0] CRC_INIT_RST = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY_RST = 8'h31;
  localparam logic              AVG_MODE_RST = 1'b1;
  localparam logic [CNT_W-1:0]  LIMIT_RST    = 5'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRC_INIT     = 2'd0,
    REG_CRC_POLY     = 2'd1,
    REG_AVG_MODE     = 2'd2,
    REG_SAMPLE_LIMIT = 2'd3
  } cfg_reg_t;

  // role of a byte inside its word
  typedef enum logic [1:0] {
    KIND_HI  = 2'd0,
    KIND_LO  = 2'd1,
    KIND_CRC = 2'd2
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t          kind;
    logic [WIDX_W-1:0]   word;
  } pos_info_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_STEP = 3'd1,
    ST_DIV  = 3'd2,
    ST_MUL  = 3'd3,
    ST_FIX  = 3'd4,
    ST_PUSH = 3'd5
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic step;
    logic div_step;
    logic mul;
    logic fix;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // byte position within the frame to word and byte role
  function automatic pos_info_t pos_decode(input logic [POS_W-1:0] pos);
    pos_info_t pi;
    unique case (pos)
      4'd0:    pi = '{kind: KIND_HI,  word: 2'd0};
      4'd1:    pi = '{kind: KIND_LO,  word: 2'd0};
      4'd2:    pi = '{kind: KIND_CRC, word: 2'd0};
      4'd3:    pi = '{kind: KIND_HI,  word: 2'd1};
      4'd4:    pi = '{kind: KIND_LO,  word: 2'd1};
      4'd5:    pi = '{kind: KIND_CRC, word: 2'd1};
      4'd6:    pi = '{kind: KIND_HI,  word: 2'd2};
      4'd7:    pi = '{kind: KIND_LO,  word: 2'd2};
      default: pi = '{kind: KIND_CRC, word: 2'd2};
    endcase
    return pi;
  endfunction

  // eight msb-first crc shifts of one byte
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = c_in;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/co2fca_ctrl.sv =====
// controller state machine of the co2 frame check and average block
`timescale 1ns / 1ps
`default_nettype none

module co2fca_ctrl
  import co2fca_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = status.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/co2fca_dp.sv =====
// datapath: frame crc check, sample sums, shared divider, scaling and result register
`timescale 1ns / 1ps
`default_nettype none

module co2fca_dp
  import co2fca_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [BYTE_W-1:0]        cfg_wdata,
  input  wire logic                     in_func,
  input  wire logic [BYTE_W-1:0]        in_rx_byte,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic [WORD_W-1:0]             out_co2_ppm,
  output logic signed [TEMP_W-1:0]      out_temp_centi,
  output logic [HUM_W-1:0]              out_humid_centi,
  output logic                          out_result_valid,
  output logic [CNT_W-1:0]              out_samples_used,
  input  wire dp_cmd_t                  cmd,
  output dp_status_t                    status
);

  localparam logic [CNT_W-1:0]    MAX_LIM    = CNT_W'(MAX_SAMPLES);
  localparam logic [DCNT_W-1:0]   DIV_LAST   = DCNT_W'(SUM_W - 1);
  localparam logic [WIDX_W-1:0]   WORD_LAST  = WIDX_W'(NWORDS - 1);
  localparam logic [PROD_W-1:0]   TEMP_SPAN  = PROD_W'(17500);
  localparam logic [PROD_W-1:0]   HUM_SPAN   = PROD_W'(10000);
  localparam logic [TEMP_W-1:0]   TEMP_OFFS  = TEMP_W'(4500);
  localparam logic [POS_W-1:0]    POS_LAST   = POS_W'(8);

  // floor(x / 65535) for x below 2^31: quotient by 2^16 is short by at most one
  function automatic logic [WORD_W-1:0] div_ffff(input logic [PROD_W-1:0] x);
    logic [PROD_W-WORD_W-1:0] q0;
    logic [WORD_W:0]          r0;
    q0 = x[PROD_W-1:WORD_W];
    r0 = {1'b0, x[WORD_W-1:0]} + (WORD_W+1)'(q0);
    if (r0 >= (WORD_W+1)'(17'h0FFFF)) begin
      return WORD_W'(q0) + WORD_W'(1);
    end
    return WORD_W'(q0);
  endfunction

  // configuration registers
  logic [BYTE_W-1:0] crc_init_r, crc_poly_r;
  logic              avg_mode_r;
  logic [CNT_W-1:0]  limit_r;

  // input latch
  logic              fn_r, fn_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;

  // frame and run state
  logic [POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [BYTE_W-1:0] crc_run_r, crc_run_nxt;
  logic              frame_ok_r, frame_ok_nxt;
  logic [WORD_W-1:0] word_hold_r [NWORDS];
  logic [WORD_W-1:0] word_hold_nxt [NWORDS];
  logic [SUM_W-1:0]  sums_r [NWORDS];
  logic [SUM_W-1:0]  sums_nxt [NWORDS];
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [CNT_W-1:0]  tried_r, tried_nxt;

  // divider
  logic [SUM_W-1:0]  op_r [NWORDS];
  logic [SUM_W-1:0]  op_nxt [NWORDS];
  logic [SUM_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [WORD_W-1:0] q_r [NWORDS];
  logic [WORD_W-1:0] q_nxt [NWORDS];

  // scaling
  logic [PROD_W-1:0] prod_t_r, prod_t_nxt, prod_h_r, prod_h_nxt;
  logic [TEMP_W-1:0] t_r, t_nxt;
  logic [HUM_W-1:0]  h_r, h_nxt;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]        co2_r, co2_nxt;
  logic [TEMP_W-1:0]        temp_r, temp_nxt;
  logic [HUM_W-1:0]         hum_r, hum_nxt;
  logic                     rv_r, rv_nxt;
  logic [CNT_W-1:0]         used_r, used_nxt;

  // step scratch
  logic [POS_W-1:0]  pos;
  pos_info_t         pi;
  logic [CNT_W-1:0]  limit;
  logic              sample_end, sample_ok, ok_now, emit;
  logic [CNT_W-1:0]  tried_inc, good_plus, n_new;
  logic [SUM_W-1:0]  sums_plus [NWORDS];
  logic [SUM_W-1:0]  op_new [NWORDS];
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  assign pos   = (byte_pos_r > POS_LAST) ? '0 : byte_pos_r;
  assign pi    = pos_decode(pos);
  assign limit = (limit_r == '0) ? CNT_W'(1) : ((limit_r > MAX_LIM) ? MAX_LIM : limit_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r <= CRC_INIT_RST;
      crc_poly_r <= CRC_POLY_RST;
      avg_mode_r <= AVG_MODE_RST;
      limit_r    <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CRC_INIT:     crc_init_r <= cfg_wdata;
        REG_CRC_POLY:     crc_poly_r <= cfg_wdata;
        REG_AVG_MODE:     avg_mode_r <= cfg_wdata[0];
        REG_SAMPLE_LIMIT: limit_r    <= cfg_wdata[CNT_W-1:0];
        default:          crc_init_r <= crc_init_r;
      endcase
    end
  end

  always_comb begin
    fn_nxt        = fn_r;
    byte_nxt      = byte_r;
    byte_pos_nxt  = byte_pos_r;
    crc_run_nxt   = crc_run_r;
    frame_ok_nxt  = frame_ok_r;
    word_hold_nxt = word_hold_r;
    sums_nxt      = sums_r;
    good_nxt      = good_r;
    tried_nxt     = tried_r;
    op_nxt        = op_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    widx_nxt      = widx_r;
    n_nxt         = n_r;
    q_nxt         = q_r;
    prod_t_nxt    = prod_t_r;
    prod_h_nxt    = prod_h_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    out_valid_nxt = out_valid_r;
    co2_nxt       = co2_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    rv_nxt        = rv_r;
    used_nxt      = used_r;

    sample_end = 1'b0;
    sample_ok  = 1'b0;
    ok_now     = frame_ok_r && (crc_run_r == byte_r);
    emit       = 1'b0;
    tried_inc  = tried_r + CNT_W'(1);
    good_plus  = good_r;
    n_new      = '0;
    for (int k = 0; k < NWORDS; k++) begin
      sums_plus[k] = sums_r[k];
      op_new[k]    = '0;
    end

    if (cmd.latch) begin
      fn_nxt   = in_func;
      byte_nxt = in_rx_byte;
    end

    // one frame byte or timeout
    if (cmd.step) begin
      if (fn_r) begin
        byte_pos_nxt = '0;
        crc_run_nxt  = crc_init_r;
        frame_ok_nxt = 1'b1;
        sample_end   = 1'b1;
      end else if (pi.kind != KIND_CRC) begin
        crc_run_nxt  = crc8_byte(((pi.kind == KIND_HI) ? crc_init_r : crc_run_r) ^ byte_r,
                                 crc_poly_r);
        if (pi.kind == KIND_HI) begin
          word_hold_nxt[pi.word] = {byte_r, 8'h00};
        end else begin
          word_hold_nxt[pi.word][BYTE_W-1:0] = byte_r;
        end
        byte_pos_nxt = pos + POS_W'(1);
      end else begin
        crc_run_nxt = crc_init_r;
        if (pos != POS_LAST) begin
          byte_pos_nxt = pos + POS_W'(1);
          frame_ok_nxt = ok_now;
        end else begin
          byte_pos_nxt = '0;
          frame_ok_nxt = 1'b1;
          sample_end   = 1'b1;
          sample_ok    = ok_now;
        end
      end

      if (sample_end) begin
        if (avg_mode_r) begin
          if (sample_ok) begin
            for (int k = 0; k < NWORDS; k++) begin
              sums_plus[k] = sums_r[k] + SUM_W'(word_hold_r[k]);
            end
            good_plus = good_r + CNT_W'(1);
          end
          if (tried_inc >= limit) begin
            emit   = 1'b1;
            op_new = sums_plus;
            n_new  = good_plus;
          end else begin
            sums_nxt  = sums_plus;
            good_nxt  = good_plus;
            tried_nxt = tried_inc;
          end
        end else if (sample_ok) begin
          emit = 1'b1;
          for (int k = 0; k < NWORDS; k++) begin
            op_new[k] = SUM_W'(word_hold_r[k]);
          end
          n_new = CNT_W'(1);
        end else if (tried_inc >= limit) begin
          emit = 1'b1;
        end else begin
          tried_nxt = tried_inc;
        end
      end

      // run ends: clear sums and start the divider on the first word
      if (emit) begin
        for (int k = 0; k < NWORDS; k++) begin
          sums_nxt[k] = '0;
        end
        good_nxt  = '0;
        tried_nxt = '0;
        op_nxt    = op_new;
        num_nxt   = op_new[0];
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        widx_nxt  = '0;
        n_nxt     = n_new;
      end
    end

    // restoring division, one quotient bit per cycle
    rem_sh = {rem_r, num_r[SUM_W-1]};
    ge     = rem_sh >= {1'b0, n_r};
    if (cmd.div_step) begin
      rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, n_r}) : CNT_W'(rem_sh);
      num_nxt  = {num_r[SUM_W-2:0], ge};
      dcnt_nxt = dcnt_r + DCNT_W'(1);
      if (dcnt_r == DIV_LAST) begin
        q_nxt[widx_r] = num_nxt[WORD_W-1:0];
        dcnt_nxt      = '0;
        rem_nxt       = '0;
        if (widx_r != WORD_LAST) begin
          widx_nxt = widx_r + WIDX_W'(1);
          num_nxt  = op_r[widx_r + WIDX_W'(1)];
        end
      end
    end

    if (cmd.mul) begin
      prod_t_nxt = TEMP_SPAN * PROD_W'(q_r[1]);
      prod_h_nxt = HUM_SPAN * PROD_W'(q_r[2]);
    end

    if (cmd.fix) begin
      t_nxt = TEMP_W'(div_ffff(prod_t_r));
      h_nxt = HUM_W'(div_ffff(prod_h_r));
    end

    // result register
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      if (n_r == '0) begin
        co2_nxt  = '0;
        temp_nxt = '0;
        hum_nxt  = '0;
        rv_nxt   = 1'b0;
        used_nxt = '0;
      end else begin
        co2_nxt  = q_r[0];
        temp_nxt = t_r - TEMP_OFFS;
        hum_nxt  = h_r;
        rv_nxt   = 1'b1;
        used_nxt = n_r;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      crc_run_r   <= CRC_INIT_RST;
      frame_ok_r  <= 1'b1;
      word_hold_r <= '{default: '0};
      sums_r      <= '{default: '0};
      good_r      <= '0;
      tried_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      crc_run_r   <= crc_run_nxt;
      frame_ok_r  <= frame_ok_nxt;
      word_hold_r <= word_hold_nxt;
      sums_r      <= sums_nxt;
      good_r      <= good_nxt;
      tried_r     <= tried_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    fn_r     <= fn_nxt;
    byte_r   <= byte_nxt;
    op_r     <= op_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    dcnt_r   <= dcnt_nxt;
    widx_r   <= widx_nxt;
    n_r      <= n_nxt;
    q_r      <= q_nxt;
    prod_t_r <= prod_t_nxt;
    prod_h_r <= prod_h_nxt;
    t_r      <= t_nxt;
    h_r      <= h_nxt;
    co2_r    <= co2_nxt;
    temp_r   <= temp_nxt;
    hum_r    <= hum_nxt;
    rv_r     <= rv_nxt;
    used_r   <= used_nxt;
  end

  assign status.emit     = emit;
  assign status.div_done = (dcnt_r == DIV_LAST) && (widx_r == WORD_LAST);
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_co2_ppm      = co2_r;
  assign out_temp_centi   = $signed(temp_r);
  assign out_humid_centi  = hum_r;
  assign out_result_valid = rv_r;
  assign out_samples_used = used_r;

endmodule

`default_nettype wire

// ===== design/co2_frame_check_average_core.sv =====
// top level of the co2 frame check and average block
//
// input channel: one transfer per frame byte (in_func 0, byte on in_rx_byte)
//   or per timeout event (in_func 1), which drops the frame in progress and
//   counts as one failed sample
// a frame is three words of high byte, low byte, crc-8 byte
// result channel: one transfer when a run of samples ends, in first-valid
//   mode at the first good sample or after sample_limit failures, in average
//   mode after sample_limit samples
// cfg port: write index 0 crc_init, 1 crc_poly, 2 avg_mode, 3 sample_limit
// input handling: each input transfer is accepted, then handled in one processing
//   step with a combinational 8-bit crc; the next transfer waits for that step
// result path: a run-ending transfer puts its result on the output register
//   after the shared restoring divider has taken each of the three sums in
//   turn, then the multiply and the /65535 fixup
// no input is taken while a result is being computed
// receiver stall: a finished result waits in the output register; inputs
//   keep flowing until the next result is ready, which then waits for the
//   output register to free up
// reset (synchronous, rst_n low): registers to defaults, frame and run
//   cleared, output channel empty
`timescale 1ns / 1ps
`default_nettype none

module co2_frame_check_average_core
  import co2fca_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [BYTE_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_func,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_W-1:0]          out_co2_ppm,
  output logic signed [TEMP_W-1:0]   out_temp_centi,
  output logic [HUM_W-1:0]           out_humid_centi,
  output logic                       out_result_valid,
  output logic [CNT_W-1:0]           out_samples_used
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  co2fca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  co2fca_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_co2_ppm      (out_co2_ppm),
    .out_temp_centi   (out_temp_centi),
    .out_humid_centi  (out_humid_centi),
    .out_result_valid (out_result_valid),
    .out_samples_used (out_samples_used),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

`default_nettype wire

// ===== design/co2fca_checker.sv =====
// port-level checks of the co2 frame check and average block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module co2fca_checker
  import co2fca_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [WORD_W-1:0]     out_co2_ppm,
  input  wire logic signed [TEMP_W-1:0] out_temp_centi,
  input  wire logic [HUM_W-1:0]      out_humid_centi,
  input  wire logic                  out_result_valid,
  input  wire logic [CNT_W-1:0]      out_samples_used
);

  // result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result channel not empty after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_co2_ppm)
      && $stable(out_temp_centi) && $stable(out_humid_centi)
      && $stable(out_result_valid) && $stable(out_samples_used))
    else $error("stalled result changed");

  // a result with no good sample is all zeros
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |-> out_co2_ppm == '0 && out_temp_centi == '0
      && out_humid_centi == '0 && out_samples_used == '0)
    else $error("empty result not zero");

  // a good result uses between one and the most samples, with values in range
  a_good_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_valid |-> out_samples_used != '0
      && out_samples_used <= CNT_W'(MAX_SAMPLES)
      && out_temp_centi >= -TEMP_W'(4500) && out_humid_centi <= HUM_W'(10000))
    else $error("good result out of range");

endmodule

bind co2_frame_check_average_core co2fca_checker u_co2fca_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the co2 frame check and average core
`timescale 1ns / 1ps

module testbench;
  import co2fca_pkg::*;

  // meaning of in_func
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // cycles to let pass once nothing is pending, past the result computation
  localparam int SETTLE_CYCLES = 100;

  // number of random input transfers after the directed tests
  localparam int RANDOM_ITEMS = 950;

  // one reading as it leaves the result channel
  typedef struct packed {
    logic [WORD_W-1:0]        co2;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         humid;
    logic                     rvalid;
    logic [CNT_W-1:0]         used;
  } reading_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // block inputs, all known from time zero
  logic              cfg_wr_en = 1'b0;
  cfg_reg_t          cfg_index = REG_CRC_INIT;
  logic [BYTE_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_func = FUNC_BYTE;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_stall = 1'b0;

  // block outputs
  logic                     in_stall;
  logic                     out_valid;
  logic [WORD_W-1:0]        out_co2_ppm;
  logic signed [TEMP_W-1:0] out_temp_centi;
  logic [HUM_W-1:0]         out_humid_centi;
  logic                     out_result_valid;
  logic [CNT_W-1:0]         out_samples_used;

  co2_frame_check_average_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_co2_ppm      (out_co2_ppm),
    .out_temp_centi   (out_temp_centi),
    .out_humid_centi  (out_humid_centi),
    .out_result_valid (out_result_valid),
    .out_samples_used (out_samples_used)
  );

  // random idling on either side, switched per test phase
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  int mismatches = 0;
  int sent_cnt = 0;

  // readings the decoder model has produced and the block has not yet delivered
  reading_t pending_readings[$];

  // shadow copy of the configuration registers
  logic [BYTE_W-1:0] reg_crc_init;
  logic [BYTE_W-1:0] reg_crc_poly;
  logic              reg_avg_mode;
  logic [CNT_W-1:0]  reg_limit;

  // decoder model state: frame in progress and run of samples
  logic [POS_W-1:0]  dec_pos;
  logic [BYTE_W-1:0] dec_crc;
  logic [WORD_W-1:0] dec_word [NWORDS];
  logic              dec_frame_ok;
  logic [SUM_W-1:0]  run_sum [NWORDS];
  int unsigned       run_good;
  int unsigned       run_tried;

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  // crc-8 over one byte, msb first, poly with implicit x^8
  function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] c_in,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = c_in ^ b;
    repeat (BYTE_W) c = {c[BYTE_W-2:0], 1'b0} ^ (c[BYTE_W-1] ? poly : '0);
    return c;
  endfunction

  // raw words to ppm and hundredths; an empty run gives all zeros, temp included
  function automatic reading_t scale_reading(input int unsigned co2, input int unsigned traw,
                                             input int unsigned hraw, input int unsigned n);
    reading_t r;
    int t;
    int unsigned h;
    r = '0;
    if (n != 0) begin
      t = -4500 + int'((17500 * (traw & 32'hFFFF)) / 65535);
      h = (10000 * (hraw & 32'hFFFF)) / 65535;
      r.co2    = co2[WORD_W-1:0];
      r.temp   = t[TEMP_W-1:0];
      r.humid  = h[HUM_W-1:0];
      r.rvalid = 1'b1;
      r.used   = n[CNT_W-1:0];
    end
    return r;
  endfunction

  function automatic void clear_frame();
    dec_pos = '0;
    dec_crc = reg_crc_init;
    dec_frame_ok = 1'b1;
  endfunction

  function automatic void clear_run();
    for (int k = 0; k < NWORDS; k++) run_sum[k] = '0;
    run_good = 0;
    run_tried = 0;
  endfunction

  function automatic void reset_model();
    reg_crc_init = CRC_INIT_RST;
    reg_crc_poly = CRC_POLY_RST;
    reg_avg_mode = AVG_MODE_RST;
    reg_limit    = LIMIT_RST;
    for (int k = 0; k < NWORDS; k++) dec_word[k] = '0;
    clear_frame();
    clear_run();
  endfunction

  // end of one sample, good or failed; mode and limit are taken as they stand now
  function automatic void close_sample(input bit good);
    int unsigned lim;
    lim = (reg_limit == 0) ? 1 : ((reg_limit > MAX_SAMPLES) ? MAX_SAMPLES : reg_limit);
    run_tried++;
    if (reg_avg_mode) begin
      if (good) begin
        for (int k = 0; k < NWORDS; k++) run_sum[k] += dec_word[k];
        run_good++;
      end
      if (run_tried >= lim) begin
        if (run_good != 0) begin
          pending_readings.push_back(scale_reading(run_sum[0] / run_good,
                                                   run_sum[1] / run_good,
                                                   run_sum[2] / run_good, run_good));
        end else begin
          pending_readings.push_back(scale_reading(0, 0, 0, 0));
        end
        clear_run();
      end
    end else if (good) begin
      // first-valid mode: the good sample stands alone, partial sums dropped
      pending_readings.push_back(scale_reading(dec_word[0], dec_word[1], dec_word[2], 1));
      clear_run();
    end else if (run_tried >= lim) begin
      pending_readings.push_back(scale_reading(0, 0, 0, 0));
      clear_run();
    end
  endfunction

  // one accepted input transfer
  function automatic void advance_decoder(input logic f, input logic [BYTE_W-1:0] b);
    int unsigned pos;
    int unsigned w;
    byte_kind_t kind;
    bit good;
    if (f == FUNC_TIMEOUT) begin
      // partial frame dropped, counts as a failed sample
      clear_frame();
      close_sample(1'b0);
      return;
    end
    pos = (dec_pos > 8) ? 0 : dec_pos;
    kind = byte_kind_t'(pos % 3);
    w = pos / 3;
    if (kind != KIND_CRC) begin
      // start value is picked up at the high byte, polynomial at every byte
      dec_crc = crc_step((kind == KIND_HI) ? reg_crc_init : dec_crc, b, reg_crc_poly);
      if (kind == KIND_HI) dec_word[w] = {b, 8'h00};
      else dec_word[w][BYTE_W-1:0] = b;
      dec_pos = POS_W'(pos + 1);
    end else begin
      if (dec_crc != b) dec_frame_ok = 1'b0;
      dec_crc = reg_crc_init;
      if (pos < 8) begin
        dec_pos = POS_W'(pos + 1);
      end else begin
        good = dec_frame_ok;
        clear_frame();
        close_sample(good);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall and checking
  // ---------------------------------------------------------------------------

  // optionally stall ahead of every result, then hold stall low until it goes
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = stalls_on ? $urandom_range(0, 5) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every result transfer is held against the oldest pending reading
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, actual co2 %0d temp %0d humid %0d",
                 $time, out_co2_ppm, out_temp_centi, out_humid_centi);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        report_field("co2_ppm", want.co2, out_co2_ppm);
        report_field("temp_centi", $signed(want.temp), $signed(out_temp_centi));
        report_field("humid_centi", want.humid, out_humid_centi);
        report_field("result_valid", want.rvalid, out_result_valid);
        report_field("samples_used", want.used, out_samples_used);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one input transfer after a random gap; valid stays up if the next one follows at once
  task automatic send_item(input logic f, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    advance_decoder(f, b);
    sent_cnt++;
  endtask

  // drop valid, let every pending reading arrive and the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only happen once the block is quiet
  task automatic cfg_write(input cfg_reg_t idx, input logic [BYTE_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_CRC_INIT:     reg_crc_init = v;
      REG_CRC_POLY:     reg_crc_poly = v;
      REG_AVG_MODE:     reg_avg_mode = v[0];
      REG_SAMPLE_LIMIT: reg_limit = v[CNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // high byte, low byte and crc under the current registers, crc optionally broken
  task automatic send_word(input logic [WORD_W-1:0] w, input bit corrupt);
    logic [BYTE_W-1:0] c;
    c = crc_step(crc_step(reg_crc_init, w[15:8], reg_crc_poly), w[7:0], reg_crc_poly);
    if (corrupt) c ^= BYTE_W'($urandom_range(1, 255));
    send_item(FUNC_BYTE, w[15:8]);
    send_item(FUNC_BYTE, w[7:0]);
    send_item(FUNC_BYTE, c);
  endtask

  // bad_word picks a word whose crc is broken, -1 for a clean frame
  task automatic send_frame(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                            input logic [WORD_W-1:0] w2, input int bad_word);
    send_word(w0, bad_word == 0);
    send_word(w1, bad_word == 1);
    send_word(w2, bad_word == 2);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_item(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_timeout();
    send_item(FUNC_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers at reset: average of three samples with the word extremes
  task automatic test_reset_defaults();
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, -1);
    send_frame(16'h0000, 16'h0000, 16'h0000, -1);
    send_frame(16'h8000, 16'h7FFF, 16'h0001, -1);
  endtask

  // first-valid mode, top and bottom of the scales
  task automatic test_first_valid();
    cfg_write(REG_AVG_MODE, 8'h00);
    cfg_write(REG_SAMPLE_LIMIT, 8'h01);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, -1);
    send_frame(16'h0000, 16'h0000, 16'h0000, -1);
  endtask

  // crc failures and timeouts, including one that cuts a frame short
  task automatic test_failed_samples();
    cfg_write(REG_SAMPLE_LIMIT, 8'h02);
    send_frame(16'h1234, 16'h5678, 16'h9ABC, 2);
    send_timeout();
    send_noise(4);
    send_timeout();
    send_frame(16'h0190, 16'h6666, 16'h8000, -1);
  endtask

  // limit of zero acts as one, anything past the maximum clamps
  task automatic test_limit_range();
    cfg_write(REG_SAMPLE_LIMIT, 8'h00);
    send_timeout();
    cfg_write(REG_AVG_MODE, 8'hFF);
    cfg_write(REG_SAMPLE_LIMIT, 8'hF1);
    // full-width sums: sixteen samples, mostly all-ones words
    repeat (MAX_SAMPLES) send_frame(16'hFFFF, 16'hFFFF, rand_word(), -1);
  endtask

  // lowering the limit ends the run at the next sample
  task automatic test_limit_lowered();
    cfg_write(REG_SAMPLE_LIMIT, 8'h04);
    send_frame(16'h0400, 16'h4000, 16'hC000, -1);
    send_timeout();
    cfg_write(REG_SAMPLE_LIMIT, 8'h01);
    send_frame(16'h0401, 16'h4001, 16'hC001, -1);
  endtask

  // mode flips mid-run; a first-valid hit clears the partial sums
  task automatic test_mode_change();
    cfg_write(REG_SAMPLE_LIMIT, 8'h03);
    send_frame(16'hAAAA, 16'h5555, 16'h3333, -1);
    cfg_write(REG_AVG_MODE, 8'h00);
    send_frame(16'h0320, 16'h7000, 16'h2000, -1);
    cfg_write(REG_AVG_MODE, 8'h01);
    cfg_write(REG_SAMPLE_LIMIT, 8'h02);
    send_frame(16'h0001, 16'h0003, 16'h0005, -1);
    send_frame(16'h0002, 16'h0004, 16'h0007, -1);
  endtask

  // poly change applies from the next byte, start value only from the next word
  task automatic test_crc_regs_mid_word();
    logic [BYTE_W-1:0] c;
    cfg_write(REG_AVG_MODE, 8'h00);
    cfg_write(REG_SAMPLE_LIMIT, 8'h01);
    cfg_write(REG_CRC_INIT, 8'h5A);
    cfg_write(REG_CRC_POLY, 8'h31);
    c = crc_step(reg_crc_init, 8'hA5, reg_crc_poly);
    send_item(FUNC_BYTE, 8'hA5);
    cfg_write(REG_CRC_POLY, 8'h07);
    cfg_write(REG_CRC_INIT, 8'h00);
    c = crc_step(c, 8'h3C, reg_crc_poly);
    send_item(FUNC_BYTE, 8'h3C);
    send_item(FUNC_BYTE, c);
    send_word(16'h1234, 1'b0);
    send_word(16'hFEDC, 1'b0);
  endtask

  function automatic logic [BYTE_W-1:0] rand_crc_reg();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // phases of random registers and mostly clean frames, with broken frames,
  // timeouts and stray bytes mixed in; registers change at arbitrary run points
  task automatic test_random_traffic();
    int base;
    int unsigned sel;
    int unsigned n;
    base = sent_cnt;
    while (sent_cnt - base < RANDOM_ITEMS) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1)) cfg_write(REG_CRC_INIT, rand_crc_reg());
      if ($urandom_range(0, 1)) cfg_write(REG_CRC_POLY, rand_crc_reg());
      if ($urandom_range(0, 1)) cfg_write(REG_AVG_MODE, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       cfg_write(REG_SAMPLE_LIMIT, 8'd0);
          1:       cfg_write(REG_SAMPLE_LIMIT, BYTE_W'(MAX_SAMPLES));
          2:       cfg_write(REG_SAMPLE_LIMIT, BYTE_W'($urandom_range(17, 255)));
          default: cfg_write(REG_SAMPLE_LIMIT, BYTE_W'($urandom_range(1, 4)));
        endcase
      end
      repeat ($urandom_range(4, 20)) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          send_frame(rand_word(), rand_word(), rand_word(), -1);
        end else if (sel < 80) begin
          send_frame(rand_word(), rand_word(), rand_word(), $urandom_range(0, 2));
        end else if (sel < 92) begin
          send_noise($urandom_range(0, 8));
          send_timeout();
        end else begin
          // stray bytes, usually realigned by a timeout
          n = $urandom_range(1, 12);
          send_noise(n);
          if ($urandom_range(0, 9) < 7) send_timeout();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_first_valid();
    test_failed_samples();
    test_limit_range();
    test_limit_lowered();
    test_mode_change();
    test_crc_regs_mid_word();
    test_random_traffic();

    // all readings in, then a quiet tail
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
